/* rtl/core/acou_pkg.sv */
package acou_pkg;

	// Command codes
	localparam logic [2:0] CMD_BLEND   = 3'd0;
	localparam logic [2:0] CMD_LIGHTEN = 3'd1;
	localparam logic [2:0] CMD_DARKEN  = 3'd2;
	localparam logic [2:0] CMD_NUDGE   = 3'd3;
	localparam logic [2:0] CMD_HILITE  = 3'd4;
	localparam logic [2:0] CMD_SHADOW  = 3'd5;
	localparam logic [2:0] CMD_AVERAGE = 3'd6;

	localparam int CH_W   = 8;
	localparam int NUM_CH = 4;
	localparam int LUMA_W = 18;
	localparam int MIX_W  = 16;

	// Luminance weights and threshold
	localparam logic [9:0]        LUMA_R  = 10'd222;
	localparam logic [9:0]        LUMA_G  = 10'd707;
	localparam logic [9:0]        LUMA_B  = 10'd71;
	localparam logic [LUMA_W-1:0] LUMA_TH = 18'd160000;

	localparam logic [CH_W-1:0] CH_MAX   = 8'd255;
	localparam logic [CH_W-1:0] HI_FLOOR = 8'd51;
	// Smallest colour channel a hilite can give: 51 * 12 / 10
	localparam logic [CH_W-1:0] HI_MIN   = 8'd61;
	// Reciprocal of 5 in 16 fractional bits, exact for values up to 1530
	localparam logic [13:0]     RECIP5   = 14'd13108;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] color_a;
		logic [31:0] color_b;
		logic [7:0]  amount;
	} job_t;

	typedef struct packed {
		logic [31:0] color_out;
		logic        input_is_light;
	} res_t;

endpackage

/* rtl/core/acou_if.sv */
interface acou_job_if;
	import acou_pkg::*;

	logic valid;
	logic ready;
	job_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface acou_res_if;
	import acou_pkg::*;

	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/argb_color_op_unit.sv */
// ARGB8888 color operation unit.
//
// Channels: "job" carries one transaction per pixel (command, color_a,
// color_b, amount); "res" returns one transaction per job (color_out,
// input_is_light), in order. Both use valid/ready; a transaction moves at
// a rising edge of clk with valid and ready high.
//
// Throughput: one transaction per cycle, sustained while res.ready is high,
// set by a three-stage pipeline (luminance, per-channel products, divide
// by 255 and select). A job accepted on job is registered in stage 1, then
// in stage 2, then in stage 3, whose register drives res.
//
// Stall: each stage holds while the next one is full and stalled; a stage
// that is empty still fills, so bubbles close up behind a stalled receiver.
// Nothing is dropped or repeated. job.ready falls only once all three
// stages are full and res.ready is low.
//
// Reset: arst_n clears the stage valid bits at once; the pipeline is empty
// and job.ready is high as soon as reset is released.
module argb_color_op_unit (
	input logic         clk,
	input logic         arst_n,
	acou_job_if.sink    job,
	acou_res_if.source  res
);
	import acou_pkg::*;

	// Handshake chain: a stage advances when empty or when its successor moves
	logic rdy1, rdy2, rdy3;

	// Stage 1: registered job plus light flag
	logic              v_s1;
	logic [2:0]        cmd_s1;
	logic [31:0]       ca_s1;
	logic [31:0]       cb_s1;
	logic [CH_W-1:0]   amt_s1;
	logic              light_s1;

	// Stage 2: products for the linear blend, and the non-blending results
	logic              v_s2;
	logic              mix_sel_s2;
	logic [MIX_W-1:0]  sum_s2 [NUM_CH];
	logic [31:0]       alt_s2;
	logic              light_s2;

	// Stage 3: output register
	logic              v_s3;
	logic [31:0]       color_s3;
	logic              light_s3;

	assign rdy3      = !v_s3 || res.ready;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign job.ready = rdy1;

	// ---------------------------------------------------------------
	// Stage 1: luminance of color_a
	// ---------------------------------------------------------------
	logic [LUMA_W-1:0] luma;

	always_comb begin
		luma = LUMA_W'(job.data.color_a[23:16]) * LUMA_W'(LUMA_R)
		     + LUMA_W'(job.data.color_a[15:8]) * LUMA_W'(LUMA_G)
		     + LUMA_W'(job.data.color_a[7:0]) * LUMA_W'(LUMA_B);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= job.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && job.valid) begin
			cmd_s1   <= job.data.command;
			ca_s1    <= job.data.color_a;
			cb_s1    <= job.data.color_b;
			amt_s1   <= job.data.amount;
			light_s1 <= luma > LUMA_TH;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: x*(255-t) + y*t per channel, and the simple operations
	// ---------------------------------------------------------------
	logic              mix_sel;
	logic              to_white;
	logic [CH_W-1:0]   inv_t;
	logic [CH_W-1:0]   x_ch  [NUM_CH];
	logic [CH_W-1:0]   y_ch  [NUM_CH];
	logic [MIX_W-1:0]  sum_c [NUM_CH];
	logic [31:0]       alt;
	logic [CH_W-1:0]   hi_w;
	logic [10:0]       hi_p;
	logic [24:0]       hi_q;
	logic [9:0]        shd;
	logic [CH_W:0]     avg;

	always_comb begin
		inv_t    = CH_MAX - amt_s1;
		to_white = (cmd_s1 == CMD_LIGHTEN) || ((cmd_s1 == CMD_NUDGE) && !light_s1);
		case (cmd_s1)
			CMD_BLEND, CMD_LIGHTEN, CMD_DARKEN, CMD_NUDGE: mix_sel = 1'b1;
			default:                                       mix_sel = 1'b0;
		endcase

		for (int c = 0; c < NUM_CH; c++) begin
			x_ch[c] = ca_s1[c*CH_W +: CH_W];
			if (cmd_s1 == CMD_BLEND) begin
				y_ch[c] = cb_s1[c*CH_W +: CH_W];
			end else if (c == NUM_CH - 1) begin
				// Lighten, darken and nudge keep alpha as their target
				y_ch[c] = ca_s1[c*CH_W +: CH_W];
			end else begin
				y_ch[c] = to_white ? CH_MAX : '0;
			end
			sum_c[c] = MIX_W'(x_ch[c]) * MIX_W'(inv_t) + MIX_W'(y_ch[c]) * MIX_W'(amt_s1);
		end

		alt  = ca_s1;
		hi_w = '0;
		hi_p = '0;
		hi_q = '0;
		shd  = '0;
		avg  = '0;
		case (cmd_s1)
			CMD_HILITE: begin
				for (int c = 0; c < NUM_CH - 1; c++) begin
					hi_w = (x_ch[c] < HI_FLOOR) ? HI_FLOOR : x_ch[c];
					// w * 12 / 10 as (6w) / 5, division by reciprocal
					hi_p = {1'b0, hi_w, 2'b00} + {2'b00, hi_w, 1'b0};
					hi_q = 25'(hi_p) * 25'(RECIP5);
					alt[c*CH_W +: CH_W] = (hi_q[24:16] > 9'(CH_MAX)) ? CH_MAX
					                                                 : hi_q[23:16];
				end
			end
			CMD_SHADOW: begin
				for (int c = 0; c < NUM_CH - 1; c++) begin
					shd = {1'b0, x_ch[c], 1'b0} + {2'b00, x_ch[c]};
					alt[c*CH_W +: CH_W] = shd[9:2];
				end
			end
			CMD_AVERAGE: begin
				for (int c = 0; c < NUM_CH; c++) begin
					avg = {1'b0, x_ch[c]} + {1'b0, cb_s1[c*CH_W +: CH_W]};
					alt[c*CH_W +: CH_W] = avg[CH_W:1];
				end
			end
			default: begin
				alt = ca_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			mix_sel_s2 <= mix_sel;
			alt_s2     <= alt;
			light_s2   <= light_s1;
			for (int c = 0; c < NUM_CH; c++) begin
				sum_s2[c] <= sum_c[c];
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: divide by 255 and select
	// ---------------------------------------------------------------
	// For s below 65535, s / 255 == (s + 1 + (s >> 8)) >> 8
	logic [MIX_W:0] div_t [NUM_CH];
	logic [31:0]    mixed;

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			div_t[c] = {1'b0, sum_s2[c]} + (MIX_W+1)'(1)
			         + {9'b0, sum_s2[c][MIX_W-1:CH_W]};
			mixed[c*CH_W +: CH_W] = div_t[c][MIX_W-1:CH_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			color_s3 <= mix_sel_s2 ? mixed : alt_s2;
			light_s3 <= light_s2;
		end
	end

	assign res.valid               = v_s3;
	assign res.data.color_out      = color_s3;
	assign res.data.input_is_light = light_s3;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// A hilite never leaves a color channel below the raised floor
	a_hilite_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && cmd_s1 == CMD_HILITE) |->
			(alt[7:0] >= HI_MIN && alt[15:8] >= HI_MIN && alt[23:16] >= HI_MIN))
		else $error("hilite floor check");

	// A stalled stage 2 holds its channel 0 product and its other result, and stays full
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !rdy3) |=> (v_s2 && $stable(sum_s2[0]) && $stable(alt_s2)))
		else $error("stage 2 lost data under stall");

	// The input side is only stalled when every stage is full
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!job.ready |-> (v_s1 && v_s2 && v_s3 && !res.ready))
		else $error("input stalled with a bubble in the pipeline");

	// A transaction in stage 1 that cannot advance stays put
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !rdy2) |=> (v_s1 && $stable(ca_s1) && $stable(cmd_s1)))
		else $error("stage 1 lost data under stall");

endmodule
